// ----- src/ws_opc_pkg.sv -----
package ws_opc_pkg;

  localparam int HOST_BYTES_DEF = 256;
  localparam int HLEN_W         = 9;
  localparam int PORT_W         = 16;
  localparam int ACC_W          = 17;

  localparam logic [7:0] CH_W      = 8'h77;  // w
  localparam logic [7:0] CH_S      = 8'h73;  // s
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;

  localparam logic [PORT_W-1:0] PORT_WSS = 16'd443;
  localparam logic [PORT_W-1:0] PORT_WS  = 16'd80;
  localparam logic [ACC_W-1:0]  PORT_MAX = 17'd65535;
  localparam logic [2:0]        MAX_DIGITS = 3'd5;

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_HOST_START,
    PH_HOST_PLAIN,
    PH_HOST_BRACKET,
    PH_AFTER_BRACKET,
    PH_PORT,
    PH_PATH
  } phase_t;

  // scheme progress: w, s, optional second s, colon, first slash, second slash
  typedef enum logic [2:0] {
    SP_W,
    SP_S1,
    SP_S2,
    SP_COLON,
    SP_SLASH1,
    SP_SLASH2
  } scheme_t;

  // finished item handed from the parser to the result stage
  typedef struct packed {
    logic              side;
    logic              valid;
    logic              secure;
    logic [PORT_W-1:0] port;
    logic [HLEN_W-1:0] hlen;
    logic              match_pre;  // match, bar the last byte's host compare
    logic              cmp;        // last byte still needs a host compare
    logic [7:0]        cmp_byte;
  } res_t;

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    lower_byte = (c >= CH_UC_A && c <= CH_UC_Z) ? c + 8'd32 : c;
  endfunction

endpackage

// ----- src/ws_opc_ram.sv -----
module ws_opc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/ws_opc_parser.sv -----
module ws_opc_parser
  import ws_opc_pkg::*;
#(
  parameter int MAX_HOST_BYTES = HOST_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [7:0]                        char_byte,
  input  logic                              last_byte,
  input  logic                              uri_side,
  input  logic [7:0]                        ram_rdata,
  output logic                              ram_we,
  output logic                              ram_re,
  output logic [$clog2(MAX_HOST_BYTES)-1:0] ram_addr,
  output logic [7:0]                        ram_wdata,
  output logic                              res_load,
  output res_t                              res
);

  localparam int AW  = $clog2(MAX_HOST_BYTES);
  localparam int HCW = $clog2(MAX_HOST_BYTES + 1);

  phase_t            phase_r, phase_nxt;
  scheme_t           prog_r, prog_nxt;
  logic              valid_r, valid_nxt;
  logic              sec_r, sec_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [2:0]        dig_r, dig_nxt;
  logic [HCW-1:0]    cnt_r, cnt_nxt;
  logic              heq_r;
  logic              cmp_pend_r;
  logic [7:0]        cmp_byte_r;
  logic              ref_valid_r;
  logic              ref_sec_r;
  logic [PORT_W-1:0] ref_port_r;
  logic [HCW-1:0]    ref_len_r;

  logic [7:0]        lc;
  logic              add_req;
  logic              hadd;
  logic              do_cmp;
  logic              heq_cur;
  logic              valid_fin_nxt;
  logic              fin_valid;
  logic [PORT_W-1:0] fin_port;
  logic [31:0]       cnt_ext;

  assign lc = lower_byte(char_byte);

  always_comb begin
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    valid_nxt = valid_r;
    sec_nxt   = sec_r;
    acc_nxt   = acc_r;
    dig_nxt   = dig_r;
    add_req   = 1'b0;
    if (!valid_r) begin
      // error already seen: hold until the last byte
    end else if (char_byte == CH_QUEST || char_byte == CH_HASH) begin
      valid_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_SCHEME: begin
          case (prog_r)
            SP_W: begin
              if (lc == CH_W) prog_nxt = SP_S1;
              else valid_nxt = 1'b0;
            end
            SP_S1: begin
              if (lc == CH_S) prog_nxt = SP_S2;
              else valid_nxt = 1'b0;
            end
            SP_S2: begin
              if (lc == CH_S) begin
                sec_nxt  = 1'b1;
                prog_nxt = SP_COLON;
              end else if (char_byte == CH_COLON) begin
                prog_nxt = SP_SLASH1;
              end else begin
                valid_nxt = 1'b0;
              end
            end
            SP_COLON: begin
              if (char_byte == CH_COLON) prog_nxt = SP_SLASH1;
              else valid_nxt = 1'b0;
            end
            SP_SLASH1: begin
              if (char_byte == CH_SLASH) prog_nxt = SP_SLASH2;
              else valid_nxt = 1'b0;
            end
            default: begin
              if (char_byte == CH_SLASH) phase_nxt = PH_HOST_START;
              else valid_nxt = 1'b0;
            end
          endcase
        end
        PH_HOST_START: begin
          if (char_byte inside {CH_SLASH, CH_AT, CH_COLON}) begin
            valid_nxt = 1'b0;
          end else if (char_byte == CH_LBRACK) begin
            add_req   = 1'b1;
            phase_nxt = PH_HOST_BRACKET;
          end else begin
            add_req   = 1'b1;
            phase_nxt = PH_HOST_PLAIN;
          end
        end
        PH_HOST_PLAIN: begin
          if (char_byte == CH_SLASH) phase_nxt = PH_PATH;
          else if (char_byte == CH_AT) valid_nxt = 1'b0;
          else if (char_byte == CH_COLON) phase_nxt = PH_PORT;
          else add_req = 1'b1;
        end
        PH_HOST_BRACKET: begin
          if (char_byte == CH_SLASH || char_byte == CH_AT) begin
            valid_nxt = 1'b0;
          end else if (char_byte == CH_RBRACK) begin
            add_req   = 1'b1;
            phase_nxt = PH_AFTER_BRACKET;
          end else begin
            add_req = 1'b1;
          end
        end
        PH_AFTER_BRACKET: begin
          if (char_byte == CH_COLON) phase_nxt = PH_PORT;
          else if (char_byte == CH_SLASH) phase_nxt = PH_PATH;
          else valid_nxt = 1'b0;
        end
        PH_PORT: begin
          if (char_byte inside {[CH_ZERO:CH_NINE]}) begin
            if (dig_r >= MAX_DIGITS) begin
              valid_nxt = 1'b0;
            end else begin
              acc_nxt = (acc_r << 3) + (acc_r << 1)
                      + {{(ACC_W-4){1'b0}}, char_byte[3:0]};
              dig_nxt = dig_r + 3'd1;
            end
          end else if (char_byte == CH_SLASH) begin
            if (dig_r == 3'd0 || acc_r > PORT_MAX) valid_nxt = 1'b0;
            else phase_nxt = PH_PATH;
          end else begin
            valid_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // host byte store: phase has already moved above whatever the outcome
  always_comb begin
    cnt_nxt = cnt_r;
    hadd    = 1'b0;
    if (add_req && cnt_r < HCW'(MAX_HOST_BYTES)) begin
      cnt_nxt = cnt_r + 1'b1;
      hadd    = 1'b1;
    end
  end

  assign valid_fin_nxt = valid_nxt & ~(add_req & (cnt_r >= HCW'(MAX_HOST_BYTES)));

  assign do_cmp  = hadd & uri_side & (cnt_r < ref_len_r);
  assign heq_cur = heq_r & ~(cmp_pend_r & (ram_rdata != cmp_byte_r));

  assign ram_we    = accept & hadd & ~uri_side;
  assign ram_re    = accept & do_cmp;
  assign ram_addr  = cnt_r[AW-1:0];
  assign ram_wdata = lc;

  always_comb begin
    case (phase_nxt)
      PH_HOST_PLAIN, PH_AFTER_BRACKET, PH_PATH: fin_valid = valid_fin_nxt;
      PH_PORT:  fin_valid = valid_fin_nxt & (dig_nxt != 3'd0) & (acc_nxt <= PORT_MAX);
      default:  fin_valid = 1'b0;
    endcase
  end

  assign fin_port = (dig_nxt != 3'd0) ? acc_nxt[PORT_W-1:0] : (sec_nxt ? PORT_WSS : PORT_WS);
  assign cnt_ext  = 32'(cnt_nxt);

  assign res_load      = accept & last_byte;
  assign res.side      = uri_side;
  assign res.valid     = fin_valid;
  assign res.secure    = fin_valid & sec_nxt;
  assign res.port      = fin_valid ? fin_port : '0;
  assign res.hlen      = fin_valid ? cnt_ext[HLEN_W-1:0] : '0;
  assign res.match_pre = uri_side & fin_valid & ref_valid_r & (sec_nxt == ref_sec_r)
                       & (fin_port == ref_port_r) & (cnt_nxt == ref_len_r) & heq_cur;
  assign res.cmp       = do_cmp;
  assign res.cmp_byte  = lc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SCHEME;
      prog_r      <= SP_W;
      valid_r     <= 1'b1;
      sec_r       <= 1'b0;
      acc_r       <= '0;
      dig_r       <= '0;
      cnt_r       <= '0;
      heq_r       <= 1'b1;
      cmp_pend_r  <= 1'b0;
      ref_valid_r <= 1'b0;
      ref_sec_r   <= 1'b0;
      ref_port_r  <= '0;
      ref_len_r   <= '0;
    end else if (accept) begin
      cmp_pend_r <= do_cmp & ~last_byte;
      if (last_byte) begin
        phase_r <= PH_SCHEME;
        prog_r  <= SP_W;
        valid_r <= 1'b1;
        sec_r   <= 1'b0;
        acc_r   <= '0;
        dig_r   <= '0;
        cnt_r   <= '0;
        heq_r   <= 1'b1;
        if (!uri_side) begin
          ref_valid_r <= fin_valid;
          ref_sec_r   <= fin_valid & sec_nxt;
          ref_port_r  <= fin_valid ? fin_port : '0;
          ref_len_r   <= fin_valid ? cnt_nxt : '0;
        end
      end else begin
        phase_r <= phase_nxt;
        prog_r  <= prog_nxt;
        valid_r <= valid_fin_nxt;
        sec_r   <= sec_nxt;
        acc_r   <= acc_nxt;
        dig_r   <= dig_nxt;
        cnt_r   <= cnt_nxt;
        heq_r   <= heq_cur;
      end
    end else begin
      cmp_pend_r <= 1'b0;
      heq_r      <= heq_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmp_byte_r <= lc;
    end
  end

endmodule

// ----- src/ws_opc_result.sv -----
module ws_opc_result
  import ws_opc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_load,
  input  res_t        res,
  input  logic [7:0]  ram_rdata,
  output logic        in_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tuser
);

  logic        b_valid_r;
  res_t        b_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_user_r;
  logic        b_move;
  logic        b_match;

  // host RAM data stays put while this stage is blocked: reads only on accept
  assign b_match  = b_r.match_pre & ~(b_r.cmp & (ram_rdata != b_r.cmp_byte));
  assign b_move   = b_valid_r & (~out_valid_r | out_tready);
  assign in_ready = ~b_valid_r | b_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        b_valid_r <= res_load;
      end
      if (b_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res_load) begin
      b_r <= res;
    end
    if (b_move) begin
      out_data_r <= {4'b0000, b_match, b_r.hlen, b_r.port, b_r.secure, b_r.valid};
      out_user_r <= b_r.side;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- src/ws_origin_parse_compare_top.sv -----
// Channel  Ports                          Contents (lowest bit first)
// in       in_tvalid/in_tready/in_tdata   char_byte[7:0]
//          in_tlast, in_tuser             last_byte, uri_side
// out      out_tvalid/out_tready/out_tdata origin_valid, secure_scheme, port_number[15:0],
//                                          host_length[8:0], origins_match, zero pad
//          out_tuser                      side_done
//
// One byte is taken per cycle while in_tready is high. A result is registered first in
// the result stage, which finishes the host compare from the host RAM's registered read,
// then in the output register. Reset is synchronous, active low.
// in_tready drops only while both the result stage and the output register hold
// results, so one waiting result does not stop the byte stream.
module ws_origin_parse_compare_top
  import ws_opc_pkg::*;
#(
  parameter int MAX_HOST_BYTES = HOST_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_byte
  input  logic        in_tlast,   // last_byte
  input  logic        in_tuser,   // uri_side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // origin_valid, secure_scheme, port_number, host_length,
                                  // origins_match
  output logic        out_tuser   // side_done
);

  localparam int AW = $clog2(MAX_HOST_BYTES);

  logic          accept;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          res_load;
  res_t          res;

  assign accept = in_tvalid & in_tready;

  ws_opc_parser #(
    .MAX_HOST_BYTES(MAX_HOST_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .char_byte(in_tdata),
    .last_byte(in_tlast),
    .uri_side (in_tuser),
    .ram_rdata(ram_rdata),
    .ram_we   (ram_we),
    .ram_re   (ram_re),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata),
    .res_load (res_load),
    .res      (res)
  );

  ws_opc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_HOST_BYTES)
  ) u_host_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  ws_opc_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .ram_rdata (ram_rdata),
    .in_ready  (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
